// ----- rtl/pn2d_pkg.sv -----
// shared types and constants for the 2d perlin noise pipeline
// no dependencies

package pn2d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TABLE_DEPTH   = 256;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W       = 8;
    localparam int COORD_W       = 32;
    localparam int OUT_W         = 18;
    localparam int OUT_FRAC      = 16;
    localparam int OUT_MAX       = 131071;
    localparam int OUT_MIN       = -131072;
    localparam int S_TDATA_W     = 2 * COORD_W + 2 * ENTRY_W;
    localparam int M_TDATA_W     = ((OUT_W + 7) / 8) * 8;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } pn2d_kind_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } pn2d_wr_t;

endpackage

// ----- rtl/perlin_noise_2d_top.sv -----
// 2d improved perlin noise, nine register stages, one transaction per cycle unless stalled
// depends on pn2d_pkg, pn2d_perm_ram, pn2d_fade

// Usage
// The slave channel carries two kinds of transaction, chosen by s_axis_tuser.
// A load transaction writes one byte of the 256-entry permutation table and
// gives no result. A query transaction carries x and y in signed fixed point
// with FRAC_BITS fraction bits and gives exactly one noise value on the master
// channel, signed with 16 fraction bits and saturated to 18 bits.
// Throughput: one transaction per cycle unless the output stalls, loads and
// queries in any mix. Path: a query accepted on an edge goes through a
// permutation read, a second hashed read from two duplicated table copies,
// a four-multiply fade, two lerp levels and the output rounding and
// saturation register before m_axis_tvalid rises for it.
// Table writes follow the transactions down the pipeline, so a query always
// sees the table as it stood when it was accepted.
// Reset clears every valid bit and holds s_axis_tready low; the table itself
// is not cleared and must be loaded before queries read it.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.

module perlin_noise_2d_top #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // coord_x, coord_y, entry_index, entry_value
    input  logic [pn2d_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // noise_value, zero padding
    output logic [pn2d_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int F     = FRAC_BITS;
    localparam int CW    = pn2d_pkg::COORD_W;
    localparam int IW    = pn2d_pkg::IDX_W;
    localparam int EW    = pn2d_pkg::ENTRY_W;
    localparam int OW    = pn2d_pkg::OUT_W;
    localparam int FW    = F + 2;
    localparam int DW    = F + 3;
    localparam int DIFW  = F + 4;
    localparam int PLW   = FW + DIFW;
    localparam int LW    = F + 4;
    localparam int LDW   = LW + 1;
    localparam int PXW   = FW + LDW;
    localparam int RW    = LW + 1;
    localparam int SH_L  = (F < pn2d_pkg::OUT_FRAC) ? pn2d_pkg::OUT_FRAC - F : 0;
    localparam int SH_R  = (F > pn2d_pkg::OUT_FRAC) ? F - pn2d_pkg::OUT_FRAC : 0;
    localparam int RND   = (1 << SH_R) >> 1;
    localparam int VW    = RW + SH_L + 2;
    localparam int HALF  = 1 << (F - 1);
    localparam int PAD_W = pn2d_pkg::M_TDATA_W - OW;
    localparam logic signed [DW-1:0] ONE_D = DW'(1 << F);

    localparam logic [1:0] GRAD_PP = 2'd0;
    localparam logic [1:0] GRAD_MP = 2'd1;
    localparam logic [1:0] GRAD_MM = 2'd2;
    localparam logic [1:0] GRAD_PM = 2'd3;

    function automatic logic signed [DW-1:0] grad_dot(
        input logic [1:0]           h,
        input logic signed [DW-1:0] dx,
        input logic signed [DW-1:0] dy
    );
        logic signed [DW-1:0] r;
        case (h)
            GRAD_PP: r = dx + dy;
            GRAD_MP: r = dy - dx;
            GRAD_MM: r = -dx - dy;
            GRAD_PM: r = dx - dy;
            default: r = '0;
        endcase
        return r;
    endfunction

    // handshake and input fields
    logic                  en;
    logic                  acc;
    logic [CW-1:0]         in_x;
    logic [CW-1:0]         in_y;
    logic [IW-1:0]         in_idx;
    logic [EW-1:0]         in_val;
    pn2d_pkg::pn2d_kind_t  in_kind;
    logic [IW-1:0]         x_cell;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && aresetn;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign in_x          = s_axis_tdata[CW-1:0];
    assign in_y          = s_axis_tdata[2*CW-1:CW];
    assign in_idx        = s_axis_tdata[2*CW+IW-1:2*CW];
    assign in_val        = s_axis_tdata[2*CW+IW+EW-1:2*CW+IW];
    assign in_kind       = pn2d_pkg::pn2d_kind_t'(s_axis_tuser[0]);
    assign x_cell        = in_x[F+IW-1:F];

    // stage 1
    logic                  v1_reg;
    pn2d_pkg::pn2d_kind_t  k1_reg;
    logic [IW-1:0]         y1_reg;
    logic [F-1:0]          fx1_reg;
    logic [F-1:0]          fy1_reg;
    logic [IW-1:0]         idx1_reg;
    logic [EW-1:0]         val1_reg;
    pn2d_pkg::pn2d_wr_t    wr_a;
    logic [EW-1:0]         pa0;
    logic [EW-1:0]         pa1;

    assign wr_a = '{we: acc && (in_kind == pn2d_pkg::KIND_LOAD), addr: in_idx, data: in_val};

    pn2d_perm_ram u_ram_a (
        .aclk   (aclk),
        .en     (en),
        .wr     (wr_a),
        .raddr0 (x_cell),
        .raddr1 (x_cell + IW'(1)),
        .rdata0 (pa0),
        .rdata1 (pa1)
    );

    // stage 2
    logic                  q2_reg;
    logic [F-1:0]          fx2_reg;
    logic [F-1:0]          fy2_reg;
    pn2d_pkg::pn2d_wr_t    wr_bc;
    logic [IW-1:0]         ab0;
    logic [IW-1:0]         ab1;
    logic [IW-1:0]         ac0;
    logic [IW-1:0]         ac1;
    logic [EW-1:0]         hbl;
    logic [EW-1:0]         htl;
    logic [EW-1:0]         hbr;
    logic [EW-1:0]         htr;

    assign wr_bc = '{we: en && v1_reg && (k1_reg == pn2d_pkg::KIND_LOAD),
                     addr: idx1_reg, data: val1_reg};
    assign ab0   = pa0 + y1_reg;
    assign ab1   = pa0 + y1_reg + IW'(1);
    assign ac0   = pa1 + y1_reg;
    assign ac1   = pa1 + y1_reg + IW'(1);

    pn2d_perm_ram u_ram_b (
        .aclk   (aclk),
        .en     (en),
        .wr     (wr_bc),
        .raddr0 (ab0),
        .raddr1 (ab1),
        .rdata0 (hbl),
        .rdata1 (htl)
    );

    pn2d_perm_ram u_ram_c (
        .aclk   (aclk),
        .en     (en),
        .wr     (wr_bc),
        .raddr0 (ac0),
        .raddr1 (ac1),
        .rdata0 (hbr),
        .rdata1 (htr)
    );

    // fade curves, valid at stage 4
    logic signed [FW-1:0] fade_u;
    logic signed [FW-1:0] fade_v;

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .aclk (aclk),
        .en   (en),
        .t    (fx1_reg),
        .fade (fade_u)
    );

    pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .aclk (aclk),
        .en   (en),
        .t    (fy1_reg),
        .fade (fade_v)
    );

    // stage 3: gradient dot products
    logic signed [DW-1:0] dx0;
    logic signed [DW-1:0] dx1;
    logic signed [DW-1:0] dy0;
    logic signed [DW-1:0] dy1;
    logic                 q3_reg;
    logic signed [DW-1:0] dbl3_reg;
    logic signed [DW-1:0] dtl3_reg;
    logic signed [DW-1:0] dbr3_reg;
    logic signed [DW-1:0] dtr3_reg;

    assign dx0 = DW'($signed({1'b0, fx2_reg}));
    assign dy0 = DW'($signed({1'b0, fy2_reg}));
    assign dx1 = dx0 - ONE_D;
    assign dy1 = dy0 - ONE_D;

    // stage 4
    logic                 q4_reg;
    logic signed [DW-1:0] dbl4_reg;
    logic signed [DW-1:0] dtl4_reg;
    logic signed [DW-1:0] dbr4_reg;
    logic signed [DW-1:0] dtr4_reg;

    // stage 5: lerp along y, products
    logic signed [DIFW-1:0] dif0;
    logic signed [DIFW-1:0] dif1;
    logic signed [PLW-1:0]  pl0_next;
    logic signed [PLW-1:0]  pl1_next;
    logic                   q5_reg;
    logic signed [PLW-1:0]  pl0_reg;
    logic signed [PLW-1:0]  pl1_reg;
    logic signed [DW-1:0]   dbl5_reg;
    logic signed [DW-1:0]   dbr5_reg;
    logic signed [FW-1:0]   u5_reg;

    assign dif0     = DIFW'(dtl4_reg) - DIFW'(dbl4_reg);
    assign dif1     = DIFW'(dtr4_reg) - DIFW'(dbr4_reg);
    assign pl0_next = fade_v * dif0;
    assign pl1_next = fade_v * dif1;

    // stage 6: lerp along y, sums
    logic signed [PLW-1:0] pl0_sh;
    logic signed [PLW-1:0] pl1_sh;
    logic signed [PLW-1:0] pl0_sum;
    logic signed [PLW-1:0] pl1_sum;
    logic                  q6_reg;
    logic signed [LW-1:0]  ly0_reg;
    logic signed [LW-1:0]  ly1_reg;
    logic signed [FW-1:0]  u6_reg;

    assign pl0_sum = pl0_reg + PLW'(HALF);
    assign pl1_sum = pl1_reg + PLW'(HALF);
    assign pl0_sh  = pl0_sum >>> F;
    assign pl1_sh  = pl1_sum >>> F;

    // stage 7: lerp along x, product
    logic signed [LDW-1:0] difx;
    logic signed [PXW-1:0] px_next;
    logic                  q7_reg;
    logic signed [PXW-1:0] px_reg;
    logic signed [LW-1:0]  ly0_7_reg;

    assign difx    = LDW'(ly1_reg) - LDW'(ly0_reg);
    assign px_next = u6_reg * difx;

    // stage 8: lerp along x, sum
    logic signed [PXW-1:0] px_sum;
    logic signed [PXW-1:0] px_sh;
    logic                  q8_reg;
    logic signed [RW-1:0]  r8_reg;

    assign px_sum = px_reg + PXW'(HALF);
    assign px_sh  = px_sum >>> F;

    // output stage: scale to 16 fraction bits and saturate
    logic signed [VW-1:0] r_ext;
    logic signed [VW-1:0] r_sum;
    logic signed [VW-1:0] r_conv;
    logic signed [OW-1:0] noise_next;
    logic                 m_valid_reg;
    logic signed [OW-1:0] m_noise_reg;

    assign r_ext  = VW'(r8_reg);
    assign r_sum  = (r_ext <<< SH_L) + VW'(RND);
    assign r_conv = r_sum >>> SH_R;

    always_comb begin
        if (r_conv > VW'(pn2d_pkg::OUT_MAX)) begin
            noise_next = OW'(pn2d_pkg::OUT_MAX);
        end else if (r_conv < VW'(pn2d_pkg::OUT_MIN)) begin
            noise_next = OW'(pn2d_pkg::OUT_MIN);
        end else begin
            noise_next = r_conv[OW-1:0];
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            q2_reg      <= 1'b0;
            q3_reg      <= 1'b0;
            q4_reg      <= 1'b0;
            q5_reg      <= 1'b0;
            q6_reg      <= 1'b0;
            q7_reg      <= 1'b0;
            q8_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= acc;
            q2_reg      <= v1_reg && (k1_reg == pn2d_pkg::KIND_QUERY);
            q3_reg      <= q2_reg;
            q4_reg      <= q3_reg;
            q5_reg      <= q4_reg;
            q6_reg      <= q5_reg;
            q7_reg      <= q6_reg;
            q8_reg      <= q7_reg;
            m_valid_reg <= q8_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            k1_reg      <= in_kind;
            y1_reg      <= in_y[F+IW-1:F];
            fx1_reg     <= in_x[F-1:0];
            fy1_reg     <= in_y[F-1:0];
            idx1_reg    <= in_idx;
            val1_reg    <= in_val;
            fx2_reg     <= fx1_reg;
            fy2_reg     <= fy1_reg;
            dbl3_reg    <= grad_dot(hbl[1:0], dx0, dy0);
            dtl3_reg    <= grad_dot(htl[1:0], dx0, dy1);
            dbr3_reg    <= grad_dot(hbr[1:0], dx1, dy0);
            dtr3_reg    <= grad_dot(htr[1:0], dx1, dy1);
            dbl4_reg    <= dbl3_reg;
            dtl4_reg    <= dtl3_reg;
            dbr4_reg    <= dbr3_reg;
            dtr4_reg    <= dtr3_reg;
            pl0_reg     <= pl0_next;
            pl1_reg     <= pl1_next;
            dbl5_reg    <= dbl4_reg;
            dbr5_reg    <= dbr4_reg;
            u5_reg      <= fade_u;
            ly0_reg     <= LW'(dbl5_reg) + pl0_sh[LW-1:0];
            ly1_reg     <= LW'(dbr5_reg) + pl1_sh[LW-1:0];
            u6_reg      <= u5_reg;
            px_reg      <= px_next;
            ly0_7_reg   <= ly0_reg;
            r8_reg      <= RW'(ly0_7_reg) + px_sh[RW-1:0];
            m_noise_reg <= noise_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, m_noise_reg};

    // checks
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    a_query_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |=>
        (v1_reg && (k1_reg == pn2d_pkg::KIND_QUERY)))
        else $error("accepted query missing from first stage");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v1_reg && (k1_reg == pn2d_pkg::KIND_LOAD)) |=> !q2_reg)
        else $error("load transaction entered the result pipeline");

endmodule

// ----- rtl/pn2d_perm_ram.sv -----
// permutation table copy: one write port, two registered read ports
// depends on pn2d_pkg

module pn2d_perm_ram (
    input  logic                             aclk,
    input  logic                             en,
    input  pn2d_pkg::pn2d_wr_t               wr,
    input  logic [pn2d_pkg::IDX_W-1:0]       raddr0,
    input  logic [pn2d_pkg::IDX_W-1:0]       raddr1,
    output logic [pn2d_pkg::ENTRY_W-1:0]     rdata0,
    output logic [pn2d_pkg::ENTRY_W-1:0]     rdata1
);

    logic [pn2d_pkg::ENTRY_W-1:0] mem [pn2d_pkg::TABLE_DEPTH];
    logic [pn2d_pkg::ENTRY_W-1:0] rd0_reg;
    logic [pn2d_pkg::ENTRY_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (en) begin
            rd0_reg <= mem[raddr0];
            rd1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// ----- rtl/pn2d_fade.sv -----
// three-stage quintic fade 6t^5 - 15t^4 + 10t^3 in fixed point, round half up
// depends on pn2d_pkg

module pn2d_fade #(
    parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [FRAC_BITS-1:0]        t,
    output logic signed [FRAC_BITS+1:0] fade
);

    localparam int F    = FRAC_BITS;
    localparam int TW   = F + 1;
    localparam int AW   = F + 5;
    localparam int PAW  = 2 * F + 6;
    localparam int PTW  = 2 * F + 2;
    localparam int T2W  = F + 2;
    localparam int P3W  = 2 * F + 3;
    localparam int PFW  = 2 * F + 7;
    localparam int FW   = F + 2;
    localparam int HALF = 1 << (F - 1);
    localparam logic signed [AW-1:0] C15 = AW'(15 << F);
    localparam logic signed [AW-1:0] C10 = AW'(10 << F);

    logic signed [TW-1:0]  t_s;
    logic signed [AW-1:0]  a_c;
    logic signed [PAW-1:0] ta_next;
    logic signed [PTW-1:0] tt_next;
    logic signed [PAW-1:0] ta_reg;
    logic signed [PTW-1:0] tt_reg;
    logic signed [TW-1:0]  tb_reg;
    logic signed [PAW-1:0] ta_sum;
    logic signed [PAW-1:0] ta_sh;
    logic signed [PTW-1:0] tt_sum;
    logic signed [PTW-1:0] tt_sh;
    logic signed [T2W-1:0] t2;
    logic signed [AW-1:0]  b_next;
    logic signed [P3W-1:0] t3p_next;
    logic signed [AW-1:0]  b_reg;
    logic signed [P3W-1:0] t3p_reg;
    logic signed [P3W-1:0] t3p_sum;
    logic signed [P3W-1:0] t3p_sh;
    logic signed [T2W-1:0] t3;
    logic signed [PFW-1:0] fp_next;
    logic signed [PFW-1:0] fp_reg;
    logic signed [PFW-1:0] fp_sum;
    logic signed [PFW-1:0] fp_sh;

    // stage a: t*(6t-15) and t*t
    assign t_s     = $signed({1'b0, t});
    assign a_c     = (AW'(t_s) <<< 2) + (AW'(t_s) <<< 1) - C15;
    assign ta_next = t_s * a_c;
    assign tt_next = t_s * t_s;

    // stage b: b = rnd(t*a) + 10, t3 partial = rnd(t*t) * t
    assign ta_sum   = ta_reg + PAW'(HALF);
    assign ta_sh    = ta_sum >>> F;
    assign b_next   = ta_sh[AW-1:0] + C10;
    assign tt_sum   = tt_reg + PTW'(HALF);
    assign tt_sh    = tt_sum >>> F;
    assign t2       = tt_sh[T2W-1:0];
    assign t3p_next = t2 * tb_reg;

    // stage c: rnd(t3) * b
    assign t3p_sum = t3p_reg + P3W'(HALF);
    assign t3p_sh  = t3p_sum >>> F;
    assign t3      = t3p_sh[T2W-1:0];
    assign fp_next = t3 * b_reg;

    assign fp_sum = fp_reg + PFW'(HALF);
    assign fp_sh  = fp_sum >>> F;
    assign fade   = fp_sh[FW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_reg  <= ta_next;
            tt_reg  <= tt_next;
            tb_reg  <= t_s;
            b_reg   <= b_next;
            t3p_reg <= t3p_next;
            fp_reg  <= fp_next;
        end
    end

endmodule
